// ----- hdl/rhp_pkg.sv -----
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared types and constants for the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rhp_pkg;

    // Channel and intermediate widths
    localparam int PIX_W   = 8;          // one color channel
    localparam int M_W     = 11;         // hue sixths numerator, below 6 * 255
    localparam int D_W     = 9;          // signed channel difference
    localparam int QUO_W   = 8;          // quotient bits of both dividers
    localparam int HNUM_W  = 17;         // 85 * m
    localparam int HDEN_W  = 9;          // 2 * chroma
    localparam int SNUM_W  = 16;         // 255 * chroma
    localparam int SDEN_W  = 8;          // max channel

    // Pipeline depth ahead of the dividers
    localparam int FRONT_STAGES = 2;

    // Scale factors: 255 / 360 * 60 reduces to 85 / 2 per sixth of a turn
    localparam int HUE_MUL = 85;
    localparam int SAT_MUL = 255;

    // Hue sector, picked with priority blue, green, red
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

endpackage

// ----- hdl/rhp_front.sv -----
// ----------------------------------------------------------------------------
// rhp_front
// Two register stages: max, min and sector, then dividend and divisor setup
// for the hue and saturation dividers.
// ----------------------------------------------------------------------------
module rhp_front
    import rhp_pkg::*;
(
    input  logic              clk,
    input  logic [1:0]        load,        // per-stage load enables
    input  logic [PIX_W-1:0]  red,
    input  logic [PIX_W-1:0]  green,
    input  logic [PIX_W-1:0]  blue,
    output logic [HNUM_W-1:0] hue_num,
    output logic [HDEN_W-1:0] hue_den,
    output logic [SNUM_W-1:0] sat_num,
    output logic [SDEN_W-1:0] sat_den,
    output logic [PIX_W-1:0]  value
);

    // Stage 1 combinational
    logic [PIX_W-1:0]   hi_next;
    logic [PIX_W-1:0]   lo_next;
    logic [PIX_W-1:0]   chroma_next;
    sector_t            sector_next;
    logic signed [D_W-1:0] diff_next;

    // Stage 1 registers
    logic [PIX_W-1:0]   hi_reg;
    logic [PIX_W-1:0]   chroma_reg;
    sector_t            sector_reg;
    logic signed [D_W-1:0] diff_reg;

    // Stage 2 combinational
    logic signed [M_W:0] base;
    logic signed [M_W:0] m_raw;
    logic [M_W-1:0]      m_val;
    logic [HNUM_W-1:0]   hue_num_next;
    logic [HDEN_W-1:0]   hue_den_next;
    logic [SNUM_W-1:0]   sat_num_next;
    logic [SDEN_W-1:0]   sat_den_next;

    // Stage 2 registers
    logic [HNUM_W-1:0]   hue_num_reg;
    logic [HDEN_W-1:0]   hue_den_reg;
    logic [SNUM_W-1:0]   sat_num_reg;
    logic [SDEN_W-1:0]   sat_den_reg;
    logic [PIX_W-1:0]    value_reg;

    // Max, min and sector select
    always_comb
    begin
        hi_next = (red > green) ? red : green;
        hi_next = (hi_next > blue) ? hi_next : blue;
        lo_next = (red < green) ? red : green;
        lo_next = (lo_next < blue) ? lo_next : blue;
        chroma_next = hi_next - lo_next;
        if (hi_next == blue)
        begin
            sector_next = SEC_BLUE;
            diff_next   = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        else if (hi_next == green)
        begin
            sector_next = SEC_GREEN;
            diff_next   = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sector_next = SEC_RED;
            diff_next   = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            hi_reg     <= hi_next;
            chroma_reg <= chroma_next;
            sector_reg <= sector_next;
            diff_reg   <= diff_next;
        end
    end

    // Hue in sixths of a turn times chroma: m = offset/60 * c + d, wrapped
    // into [0, 6c). Offsets 240 and 120 degrees become 4c and 2c.
    always_comb
    begin
        case (sector_reg)
            SEC_BLUE:  base = $signed({2'b00, chroma_reg, 2'b00});
            SEC_GREEN: base = $signed({3'b000, chroma_reg, 1'b0});
            default:   base = '0;
        endcase
        m_raw = base + (M_W + 1)'(diff_reg);
        if (m_raw < 0)
        begin
            // add a full turn, 6c
            m_raw = m_raw + $signed({2'b00, chroma_reg, 2'b00})
                          + $signed({3'b000, chroma_reg, 1'b0});
        end
        m_val = (chroma_reg == '0) ? '0 : m_raw[M_W-1:0];

        hue_num_next = HNUM_W'(m_val) * HNUM_W'(HUE_MUL);
        // a zero divisor becomes one so the quotient is zero
        hue_den_next = (chroma_reg == '0) ? HDEN_W'(1) : {chroma_reg, 1'b0};
        sat_num_next = SNUM_W'(chroma_reg) * SNUM_W'(SAT_MUL);
        sat_den_next = (hi_reg == '0) ? SDEN_W'(1) : hi_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            hue_num_reg <= hue_num_next;
            hue_den_reg <= hue_den_next;
            sat_num_reg <= sat_num_next;
            sat_den_reg <= sat_den_next;
            value_reg   <= hi_reg;
        end
    end

    assign hue_num = hue_num_reg;
    assign hue_den = hue_den_reg;
    assign sat_num = sat_num_reg;
    assign sat_den = sat_den_reg;
    assign value   = value_reg;

endmodule

// ----- hdl/rhp_divider.sv -----
// ----------------------------------------------------------------------------
// rhp_divider
// Pipelined restoring divider, one quotient bit per register stage. The
// quotient must fit in Q_W bits (num < den << Q_W).
// ----------------------------------------------------------------------------
module rhp_divider
    import rhp_pkg::*;
#(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8,
    parameter int Q_W   = 8
)
(
    input  logic             clk,
    input  logic [Q_W-1:0]   load,         // per-stage load enables
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    localparam int CMP_W = NUM_W + DEN_W;

    logic [NUM_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   quo_in;
        logic [CMP_W-1:0] shifted;
        logic [CMP_W-1:0] rem_ext;
        logic             ge;
        logic [CMP_W-1:0] rem_next;
        logic [Q_W-1:0]   quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // trial subtract of the divisor aligned to this quotient bit
        always_comb
        begin
            shifted  = CMP_W'(den_in) << (Q_W - 1 - k);
            rem_ext  = CMP_W'(rem_in);
            ge       = (rem_ext >= shifted);
            rem_next = ge ? (rem_ext - shifted) : rem_ext;
            quo_next = {quo_in[Q_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (load[k])
            begin
                rem_reg[k] <= rem_next[NUM_W-1:0];
                den_reg[k] <= den_in;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

// ----- hdl/rgb_to_hsv_pixel.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// 8-bit RGB to HSV pixel converter, fully pipelined.
//
//   channel   dir  tdata fields (low bit first)        tuser/tlast
//   s_axis    in   red[7:0] green[15:8] blue[23:16]     none
//   m_axis    out  hue[7:0] saturation[15:8] value[23:16]  none
//
// One pixel per clock sustained while m_axis_tready is high; the pipeline has
// 2 setup stages plus one stage per quotient bit of the two parallel 8-bit dividers.
// The last divider stage is the output register.
// Reset clears all stage valid bits; payload registers are not reset.
// Each stage holds while the one after it is full and stalled, so bubbles
// are filled and input is taken while a result waits on m_axis.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel
    import rhp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [3*PIX_W-1:0]  s_axis_tdata,   // red, green, blue
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [3*PIX_W-1:0]  m_axis_tdata    // hue, saturation, value
);

    localparam int NSTG = FRONT_STAGES + QUO_W;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG:0]   ready;
    logic [NSTG-1:0] load;

    logic [HNUM_W-1:0] hue_num;
    logic [HDEN_W-1:0] hue_den;
    logic [SNUM_W-1:0] sat_num;
    logic [SDEN_W-1:0] sat_den;
    logic [PIX_W-1:0]  value_front;
    logic [QUO_W-1:0]  hue_q;
    logic [QUO_W-1:0]  sat_q;
    logic [PIX_W-1:0]  value_reg [QUO_W];

    // Stage ready chain: a stage loads when empty or when it is draining
    always_comb
    begin
        ready[NSTG] = m_axis_tready;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        load = ready[NSTG-1:0];
        for (int i = 0; i < NSTG; i++)
        begin
            if (!load[i])
                valid_next[i] = valid_reg[i];
            else if (i == 0)
                valid_next[i] = s_axis_tvalid;
            else
                valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Max/min, sector and divider operand setup
    rhp_front u_front (
        .clk     (clk),
        .load    (load[FRONT_STAGES-1:0]),
        .red     (s_axis_tdata[PIX_W-1:0]),
        .green   (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .blue    (s_axis_tdata[3*PIX_W-1:2*PIX_W]),
        .hue_num (hue_num),
        .hue_den (hue_den),
        .sat_num (sat_num),
        .sat_den (sat_den),
        .value   (value_front)
    );

    // Hue: floor(85 * m / (2 * chroma))
    rhp_divider #(
        .NUM_W (HNUM_W),
        .DEN_W (HDEN_W),
        .Q_W   (QUO_W)
    ) u_hue_div (
        .clk  (clk),
        .load (load[NSTG-1:FRONT_STAGES]),
        .num  (hue_num),
        .den  (hue_den),
        .quo  (hue_q)
    );

    // Saturation: floor(255 * chroma / max)
    rhp_divider #(
        .NUM_W (SNUM_W),
        .DEN_W (SDEN_W),
        .Q_W   (QUO_W)
    ) u_sat_div (
        .clk  (clk),
        .load (load[NSTG-1:FRONT_STAGES]),
        .num  (sat_num),
        .den  (sat_den),
        .quo  (sat_q)
    );

    // Value rides alongside the divider stages
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            if (load[FRONT_STAGES+k])
                value_reg[k] <= (k == 0) ? value_front : value_reg[(k == 0) ? 0 : k-1];
        end
    end

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[NSTG-1];
    assign m_axis_tdata  = {value_reg[QUO_W-1], sat_q, hue_q};

    // A ready sink lets the whole pipeline advance
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    // Black or gray pixels give zero saturation and zero hue
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3*PIX_W-1:2*PIX_W] == '0)
        |-> (m_axis_tdata[2*PIX_W-1:0] == '0))
        else $error("nonzero hue or saturation for black pixel");

    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2*PIX_W-1:PIX_W] == '0)
        |-> (m_axis_tdata[PIX_W-1:0] == '0))
        else $error("nonzero hue with zero saturation");

    // Hue never reaches a full turn
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[PIX_W-1:0] != '1))
        else $error("hue out of range");

endmodule
